/* design/meter_packet_receiver_macros.svh */
// ----------------------------------------------------------------------------
// Meter packet receiver assertion macros
// Concurrent assertion forms for the receiver's frame logic.
// ----------------------------------------------------------------------------
`ifndef METER_PACKET_RECEIVER_MACROS_SVH
`define METER_PACKET_RECEIVER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MPR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication checked outside reset.
`define MPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication checked outside reset.
`define MPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

/* design/mpr_pkg.sv */
// ----------------------------------------------------------------------------
// Meter packet receiver package
// Types and constants shared by the receiver's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mpr_pkg;

  localparam int unsigned ReadingW    = 24;
  localparam int unsigned NumReadings = 7;
  localparam int unsigned IdxW        = 5;
  localparam int unsigned SlotW       = 3;

  localparam logic [7:0]      SyncByte = 8'hAE;
  localparam logic [IdxW-1:0] CheckPos = 5'd29;
  localparam logic [IdxW-1:0] FirstPos = 5'd8;

  // Request opcode.
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Result kind.
  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_BAD    = 1'b1
  } kind_e;

  // Byte position inside a three-byte reading.
  typedef enum logic [1:0] {
    POS_LOW  = 2'd0,
    POS_MID  = 2'd1,
    POS_HIGH = 2'd2
  } pos_e;

  typedef logic [NumReadings-1:0][ReadingW-1:0] reading_set_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic         valid;
    kind_e        kind;
    reading_set_t readings;
  } result_t;

endpackage

`default_nettype wire

/* design/mpr_if.sv */
// ----------------------------------------------------------------------------
// Meter packet receiver channels
// Input request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface mpr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [23:0] volts_rms;
  logic signed [23:0] amps_rms;
  logic signed [23:0] power_now;
  logic signed [23:0] power_mean;
  logic signed [23:0] power_factor;
  logic signed [23:0] line_freq;
  logic signed [23:0] energy_total;

  modport source (
    output valid, output kind, output volts_rms, output amps_rms, output power_now,
    output power_mean, output power_factor, output line_freq, output energy_total,
    input ready
  );
  modport sink (
    input valid, input kind, input volts_rms, input amps_rms, input power_now,
    input power_mean, input power_factor, input line_freq, input energy_total,
    output ready
  );
endinterface

`default_nettype wire

/* design/mpr_in_stage.sv */
// ----------------------------------------------------------------------------
// Meter packet receiver input stage
// Registers one request and releases it when the frame logic advances.
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_in_stage
  import mpr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpr_in_if.sink    in_i,
  input  wire logic advance_i,
  output logic      valid_o,
  output in_item_t  item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // Accept a new request when empty or when the held one moves on.
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{op: op_e'(in_i.op), rx_byte: in_i.rx_byte};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* design/mpr_frame.sv */
// ----------------------------------------------------------------------------
// Meter packet receiver frame logic
// Sync hunt, checksum, reading assembly, record latch and tick handling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "meter_packet_receiver_macros.svh"

module mpr_frame
  import mpr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire in_item_t item_i,
  output result_t       res_o
);

  logic            listening_q, listening_d;
  logic            rec_valid_q, rec_valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     low_q, low_d;
  pos_e            pos_q, pos_d;
  logic [SlotW-1:0] slot_q, slot_d;
  reading_set_t    frame_q;
  reading_set_t    store_q;
  logic            frame_wr;
  logic            store_ld;
  logic [7:0]      b;
  logic [7:0]      sum_next;

  assign b        = item_i.rx_byte;
  assign sum_next = sum_q + b;

  // Next-state and result logic for the request held in the input stage.
  always_comb begin
    listening_d = listening_q;
    rec_valid_d = rec_valid_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    low_d       = low_q;
    pos_d       = pos_q;
    slot_d      = slot_q;
    frame_wr    = 1'b0;
    store_ld    = 1'b0;
    res_o       = '{valid: 1'b0, kind: KIND_RECORD, readings: '0};

    if (advance_i) begin
      if (item_i.op == OP_TICK) begin
        // A tick reports the latched record and reopens listening.
        if (rec_valid_q) begin
          res_o = '{valid: 1'b1, kind: KIND_RECORD, readings: store_q};
        end
        rec_valid_d = 1'b0;
        listening_d = 1'b1;
      end else if (listening_q) begin
        if (idx_q == '0) begin
          // Hunting for the sync byte.
          if (b == SyncByte) begin
            sum_d  = b;
            idx_d  = IdxW'(1);
            pos_d  = POS_LOW;
            slot_d = '0;
          end
        end else if (idx_q < CheckPos) begin
          sum_d = sum_next;
          idx_d = idx_q + IdxW'(1);
          if (idx_q >= FirstPos) begin
            unique case (pos_q)
              POS_LOW: begin
                low_d = {8'h00, b};
                pos_d = POS_MID;
              end
              POS_MID: begin
                low_d[15:8] = b;
                pos_d       = POS_HIGH;
              end
              POS_HIGH: begin
                frame_wr = (slot_q < SlotW'(NumReadings));
                pos_d    = POS_LOW;
                slot_d   = slot_q + SlotW'(1);
              end
              default: begin
                pos_d = POS_LOW;
              end
            endcase
          end
        end else begin
          // Checksum byte: the whole frame sums to zero when good.
          idx_d = '0;
          if (sum_next == 8'h00) begin
            store_ld    = 1'b1;
            rec_valid_d = 1'b1;
            listening_d = 1'b0;
          end else begin
            res_o = '{valid: 1'b1, kind: KIND_BAD, readings: '0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listening_q <= 1'b0;
      rec_valid_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      low_q       <= '0;
      pos_q       <= POS_LOW;
      slot_q      <= '0;
    end else begin
      listening_q <= listening_d;
      rec_valid_q <= rec_valid_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      low_q       <= low_d;
      pos_q       <= pos_d;
      slot_q      <= slot_d;
    end
  end

  // Reading storage: frame in progress and latched record.
  always_ff @(posedge clk_i) begin
    if (frame_wr) begin
      frame_q[slot_q] <= {b, low_q};
    end
    if (store_ld) begin
      store_q <= frame_q;
    end
  end

  // A frame is only in progress while listening.
  `MPR_ASSERT_IMPL(a_frame_listen, clk_i, rst_ni, idx_q != '0, listening_q)
  // No result appears without a request moving through.
  `MPR_ASSERT_IMPL(a_res_adv, clk_i, rst_ni, res_o.valid, advance_i)
  // A tick always leaves the receiver listening with no pending record.
  `MPR_ASSERT_NEXT(a_tick, clk_i, rst_ni, advance_i && item_i.op == OP_TICK,
                   listening_q && !rec_valid_q)
  // A stored record ends listening and leaves the receiver hunting.
  `MPR_ASSERT_NEXT(a_store, clk_i, rst_ni, store_ld,
                   rec_valid_q && !listening_q && idx_q == '0)

endmodule

`default_nettype wire

/* design/mpr_out_stage.sv */
// ----------------------------------------------------------------------------
// Meter packet receiver output stage
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_out_stage
  import mpr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire result_t res_i,
  output logic         space_o,
  mpr_out_if.source    out_o
);

  logic         valid_q;
  kind_e        kind_q;
  reading_set_t rd_q;

  // The register can load when empty or when its result leaves this cycle.
  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_i.valid) begin
      kind_q <= res_i.kind;
      rd_q   <= res_i.readings;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.volts_rms    = signed'(rd_q[0]);
  assign out_o.amps_rms     = signed'(rd_q[1]);
  assign out_o.power_now    = signed'(rd_q[2]);
  assign out_o.power_mean   = signed'(rd_q[3]);
  assign out_o.power_factor = signed'(rd_q[4]);
  assign out_o.line_freq    = signed'(rd_q[5]);
  assign out_o.energy_total = signed'(rd_q[6]);

endmodule

`default_nettype wire

/* design/meter_packet_receiver.sv */
// Throughput: one request (byte or tick) per cycle while the result register
// has space, set by the single-pass frame logic between the input register and
// the result register, which holds each result until it is taken.
// A stalled result does not block the next request until the input register fills.
// Reset (asynchronous, active low) leaves the receiver not listening, hunting
// for sync, with no record; reading storage is not cleared.
// ----------------------------------------------------------------------------
// Meter packet receiver
// Framed power meter byte stream receiver with checksum and tick reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_packet_receiver
  import mpr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpr_in_if.sink    in_i,
  mpr_out_if.source out_o
);

  logic     s1_valid;
  in_item_t s1_item;
  logic     space;
  logic     advance;
  result_t  res;

  // The held request is processed when the result register can take it.
  assign advance = s1_valid && space;

  mpr_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  mpr_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item),
    .res_o     (res)
  );

  mpr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
